// ===== hdl/htw_pkg.sv =====
package htw_pkg;

   // Default geometry of the wheel.
   localparam int SLOTS_DEFAULT        = 64;
   localparam int LEVELS_DEFAULT       = 4;
   localparam int POOL_ENTRIES_DEFAULT = 64;

   // Field widths of the request and response channels.
   localparam int KIND_W   = 2;
   localparam int DELAY_W  = 24;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 3;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [DELAY_W-1:0] MAX_DELAY_RESET = DELAY_W'(540000);

   // Register index of max_delay_ticks.
   localparam logic REG_MAX_DELAY = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_SCHEDULE = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_TICK     = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_SCHEDULED   = 3'd0,
      STAT_POOL_FULL   = 3'd1,
      STAT_FIRED       = 3'd2,
      STAT_TICK_EMPTY  = 3'd3,
      STAT_CANCEL_DONE = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EMIT,
      S_CAN_SCAN,
      S_SCH_LVL,
      S_SCH_DIV,
      S_SCH_RD,
      S_SCH_WR,
      S_TICK_HEAD,
      S_WALK,
      S_TICK_FIN,
      S_CAS_ADV,
      S_CAS_HEAD,
      S_CAS_USE,
      S_CAS_DIV,
      S_CAS_RD,
      S_CAS_WR,
      S_CAS_NEXT
   } state_type;

endpackage

// ===== hdl/htw_if.sv =====
interface htw_req_if
   import htw_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [DELAY_W-1:0] delay_ticks;
   logic [ID_W-1:0]    cancel_id;

   modport source (output valid, kind, delay_ticks, cancel_id, input ready);
   modport sink   (input valid, kind, delay_ticks, cancel_id, output ready);
endinterface

interface htw_rsp_if
   import htw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     timer_id;
   logic                last;

   modport source (output valid, status, timer_id, last, input ready);
   modport sink   (input valid, status, timer_id, last, output ready);
endinterface

// ===== hdl/hierarchical_timer_wheel.sv =====
// Hierarchical timer wheel over a fixed pool of timer entries.
// Requests arrive on req_ch (valid/ready): schedule a timer, cancel a timer by id,
// or advance one tick. Responses leave on rsp_ch, one or more per known kind, the
// final one flagged by last. The max_delay_ticks register sits at byte address 0
// of the APB-style register port. The user must write it only while the wheel is
// idle; the block itself does not enforce this. One request is worked on at a time.
// A tick walks the entries of the expiring level-0 slot in the entry memory read loop.
// A schedule climbs one level per divide by SLOTS in the shared divider. A cancel
// scans the pool in index order. When level 0 wraps, the upper levels that carry
// are advanced and their entries cascaded down (or freed if cancelled) after the
// tick's last response; no request is taken until done.
// A finished response waits in the output register; while the receiver stalls,
// the tick walk and schedule pause and hold their place.
// Synchronous reset empties every slot, frees the whole pool, sets the next id to
// one and the delay limit to 540000. No clearing pass is needed.
module hierarchical_timer_wheel
   import htw_pkg::*;
#(
   parameter int SLOTS        = SLOTS_DEFAULT,
   parameter int LEVELS       = LEVELS_DEFAULT,
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   htw_req_if.sink               req_ch,
   htw_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   localparam int IDX_W  = $clog2(POOL_ENTRIES);
   localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SA_W   = $clog2(LEVELS * SLOTS);

   logic [DELAY_W-1:0] max_delay_ff;

   logic               ent_rd_en;
   logic [IDX_W-1:0]   ent_rd_addr;
   logic [ID_W-1:0]    ent_rd_id;
   logic [PTR_W-1:0]   ent_rd_link;
   logic               ent_wr_id_en;
   logic               ent_wr_link_en;
   logic [IDX_W-1:0]   ent_wr_addr;
   logic [ID_W-1:0]    ent_wr_id;
   logic [PTR_W-1:0]   ent_wr_link;
   logic               slot_rd_en;
   logic [SA_W-1:0]    slot_rd_addr;
   logic [PTR_W-1:0]   slot_rd_head;
   logic               slot_wr_en;
   logic [SA_W-1:0]    slot_wr_addr;
   logic [PTR_W-1:0]   slot_wr_head;
   logic               div_start;
   logic [ID_W-1:0]    div_dividend;
   logic               div_busy;
   logic [ID_W-1:0]    div_quotient;
   logic [SLOT_W-1:0]  div_remainder;

   // Register port: write on the access phase, zero-wait.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= MAX_DELAY_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_MAX_DELAY) begin
         max_delay_ff <= pwdata[DELAY_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAX_DELAY) ? CSR_DATA_W'(max_delay_ff) : '0;

   htw_ctrl #(
      .SLOTS        (SLOTS),
      .LEVELS       (LEVELS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .max_delay_ticks (max_delay_ff),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_kind        (req_ch.kind),
      .req_delay_ticks (req_ch.delay_ticks),
      .req_cancel_id   (req_ch.cancel_id),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_timer_id    (rsp_ch.timer_id),
      .rsp_last        (rsp_ch.last),
      .ent_rd_en       (ent_rd_en),
      .ent_rd_addr     (ent_rd_addr),
      .ent_rd_id       (ent_rd_id),
      .ent_rd_link     (ent_rd_link),
      .ent_wr_id_en    (ent_wr_id_en),
      .ent_wr_link_en  (ent_wr_link_en),
      .ent_wr_addr     (ent_wr_addr),
      .ent_wr_id       (ent_wr_id),
      .ent_wr_link     (ent_wr_link),
      .slot_rd_en      (slot_rd_en),
      .slot_rd_addr    (slot_rd_addr),
      .slot_rd_head    (slot_rd_head),
      .slot_wr_en      (slot_wr_en),
      .slot_wr_addr    (slot_wr_addr),
      .slot_wr_head    (slot_wr_head),
      .div_start       (div_start),
      .div_dividend    (div_dividend),
      .div_busy        (div_busy),
      .div_quotient    (div_quotient),
      .div_remainder   (div_remainder)
   );

   htw_entry_ram #(
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_entry_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (ent_rd_en),
      .rd_addr    (ent_rd_addr),
      .rd_id      (ent_rd_id),
      .rd_link    (ent_rd_link),
      .wr_id_en   (ent_wr_id_en),
      .wr_link_en (ent_wr_link_en),
      .wr_addr    (ent_wr_addr),
      .wr_id      (ent_wr_id),
      .wr_link    (ent_wr_link)
   );

   htw_slot_ram #(
      .SLOTS        (SLOTS),
      .LEVELS       (LEVELS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_head (slot_rd_head),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_head (slot_wr_head)
   );

   htw_div #(
      .DIV_W   (ID_W),
      .DIVISOR (SLOTS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .busy      (div_busy),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );
endmodule

// ===== hdl/htw_div.sv =====
module htw_div
   import htw_pkg::*;
#(
   parameter int DIV_W   = ID_W,
   parameter int DIVISOR = SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIV_W-1:0]             dividend,
   output logic                         busy,
   output logic [DIV_W-1:0]             quotient,
   output logic [$clog2(DIVISOR)-1:0]   remainder
);
   localparam int R_W = $clog2(DIVISOR);
   localparam int SH  = DIV_W + R_W;
   localparam int P_W = 2 * DIV_W + 1;
   // Rounded-up reciprocal; exact for every dividend below 2**DIV_W.
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [DIV_W:0] RECIP = RECIP_FULL[DIV_W:0];

   logic             phase_ff;
   logic [P_W-1:0]   prod_ff;
   logic [DIV_W-1:0] x_ff;
   logic [DIV_W-1:0] q_ff;
   logic [R_W-1:0]   r_ff;
   logic [P_W-1:0]   prod_shift;
   logic [DIV_W-1:0] q_next;
   logic [DIV_W-1:0] qd;
   logic [DIV_W-1:0] diff;

   // Take the quotient from the registered product and recover the remainder.
   always_comb begin
      prod_shift = prod_ff >> SH;
      q_next     = prod_shift[DIV_W-1:0];
      qd         = q_next * DIV_W'(DIVISOR);
      diff       = x_ff - qd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= start;
      end
   end

   // On start the product with the constant reciprocal is registered; then the result is.
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= P_W'(dividend) * P_W'(RECIP);
         x_ff    <= dividend;
      end else if (phase_ff) begin
         q_ff <= q_next;
         r_ff <= diff[R_W-1:0];
      end
   end

   assign busy      = phase_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule

// ===== hdl/htw_entry_ram.sv =====
module htw_entry_ram
   import htw_pkg::*;
#(
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [$clog2(POOL_ENTRIES)-1:0]       rd_addr,
   output logic [ID_W-1:0]                       rd_id,
   output logic [$clog2(POOL_ENTRIES+1)-1:0]     rd_link,
   input  logic                                  wr_id_en,
   input  logic                                  wr_link_en,
   input  logic [$clog2(POOL_ENTRIES)-1:0]       wr_addr,
   input  logic [ID_W-1:0]                       wr_id,
   input  logic [$clog2(POOL_ENTRIES+1)-1:0]     wr_link
);
   localparam int PTR_W = $clog2(POOL_ENTRIES + 1);

   logic [ID_W-1:0]         id_mem [POOL_ENTRIES];
   logic [PTR_W-1:0]        link_mem [POOL_ENTRIES];
   logic [POOL_ENTRIES-1:0] link_valid_ff;
   logic [ID_W-1:0]         rd_id_ff;
   logic [PTR_W-1:0]        rd_link_ff;

   // Link valid bits: an entry never written still holds its place in the initial free chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
      end else if (wr_link_en) begin
         link_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Storage, read-first, with registered read data.
   always_ff @(posedge clock) begin
      if (wr_id_en) begin
         id_mem[wr_addr] <= wr_id;
      end
      if (wr_link_en) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (rd_en) begin
         rd_id_ff   <= id_mem[rd_addr];
         rd_link_ff <= link_valid_ff[rd_addr] ? link_mem[rd_addr]
                                              : PTR_W'(rd_addr) + PTR_W'(1);
      end
   end

   assign rd_id   = rd_id_ff;
   assign rd_link = rd_link_ff;
endmodule

// ===== hdl/htw_slot_ram.sv =====
module htw_slot_ram
   import htw_pkg::*;
#(
   parameter int SLOTS        = SLOTS_DEFAULT,
   parameter int LEVELS       = LEVELS_DEFAULT,
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [$clog2(LEVELS*SLOTS)-1:0]       rd_addr,
   output logic [$clog2(POOL_ENTRIES+1)-1:0]     rd_head,
   input  logic                                  wr_en,
   input  logic [$clog2(LEVELS*SLOTS)-1:0]       wr_addr,
   input  logic [$clog2(POOL_ENTRIES+1)-1:0]     wr_head
);
   localparam int DEPTH = LEVELS * SLOTS;
   localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

   logic [PTR_W-1:0] head_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [PTR_W-1:0] rd_head_ff;

   // A slot never written reads as an empty chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         head_mem[wr_addr] <= wr_head;
      end
      if (rd_en) begin
         rd_head_ff <= valid_ff[rd_addr] ? head_mem[rd_addr] : NIL;
      end
   end

   assign rd_head = rd_head_ff;
endmodule

// ===== hdl/htw_ctrl.sv =====
module htw_ctrl
   import htw_pkg::*;
#(
   parameter int SLOTS        = SLOTS_DEFAULT,
   parameter int LEVELS       = LEVELS_DEFAULT,
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [DELAY_W-1:0]                    max_delay_ticks,
   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [KIND_W-1:0]                     req_kind,
   input  logic [DELAY_W-1:0]                    req_delay_ticks,
   input  logic [ID_W-1:0]                       req_cancel_id,
   // Response channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [STATUS_W-1:0]                   rsp_status,
   output logic [ID_W-1:0]                       rsp_timer_id,
   output logic                                  rsp_last,
   // Entry memory.
   output logic                                  ent_rd_en,
   output logic [$clog2(POOL_ENTRIES)-1:0]       ent_rd_addr,
   input  logic [ID_W-1:0]                       ent_rd_id,
   input  logic [$clog2(POOL_ENTRIES+1)-1:0]     ent_rd_link,
   output logic                                  ent_wr_id_en,
   output logic                                  ent_wr_link_en,
   output logic [$clog2(POOL_ENTRIES)-1:0]       ent_wr_addr,
   output logic [ID_W-1:0]                       ent_wr_id,
   output logic [$clog2(POOL_ENTRIES+1)-1:0]     ent_wr_link,
   // Slot head memory.
   output logic                                  slot_rd_en,
   output logic [$clog2(LEVELS*SLOTS)-1:0]       slot_rd_addr,
   input  logic [$clog2(POOL_ENTRIES+1)-1:0]     slot_rd_head,
   output logic                                  slot_wr_en,
   output logic [$clog2(LEVELS*SLOTS)-1:0]       slot_wr_addr,
   output logic [$clog2(POOL_ENTRIES+1)-1:0]     slot_wr_head,
   // Shared divider by SLOTS.
   output logic                                  div_start,
   output logic [ID_W-1:0]                       div_dividend,
   input  logic                                  div_busy,
   input  logic [ID_W-1:0]                       div_quotient,
   input  logic [$clog2(SLOTS)-1:0]              div_remainder
);
   localparam int IDX_W  = $clog2(POOL_ENTRIES);
   localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SA_W   = $clog2(LEVELS * SLOTS);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

   state_type               state_ff, state_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic [SLOT_W-1:0]       pos_ff [LEVELS];
   logic [SLOT_W-1:0]       pos_in [LEVELS];
   logic [PTR_W-1:0]        free_head_ff, free_head_in;
   logic [ID_W-1:0]         nid_ff, nid_in;
   logic [POOL_ENTRIES-1:0] live_ff, live_in;
   logic [POOL_ENTRIES-1:0] canc_ff, canc_in;
   logic [PTR_W-1:0]        cur_ff, cur_in;
   logic [PTR_W-1:0]        nxt_ff, nxt_in;
   logic [DELAY_W-1:0]      off_ff, off_in;
   logic [ID_W-1:0]         cid_ff, cid_in;
   logic [PTR_W-1:0]        scan_ff, scan_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic                    fire_valid_ff, fire_valid_in;
   logic [ID_W-1:0]         fire_id_ff, fire_id_in;
   status_type              emit_status_ff, emit_status_in;
   logic [SLOT_W-1:0]       slot_sel_ff, slot_sel_in;
   logic                    out_valid_ff;
   status_type              out_status_ff;
   logic [ID_W-1:0]         out_id_ff;
   logic                    out_last_ff;

   logic                    out_free;
   logic                    out_load;
   status_type              load_status;
   logic [ID_W-1:0]         load_id;
   logic                    load_last;
   logic [IDX_W-1:0]        cur_idx;
   logic [SLOT_W-1:0]       pos_next;

   function automatic logic [SA_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [SLOT_W-1:0] slot);
      slot_addr = SA_W'(int'(lvl) * SLOTS + int'(slot));
   endfunction

   function automatic logic [SLOT_W-1:0] pos_inc(input logic [SLOT_W-1:0] p);
      pos_inc = (p == SLOT_W'(SLOTS - 1)) ? '0 : p + SLOT_W'(1);
   endfunction

   // Slot position plus offset, both below SLOTS, taken modulo SLOTS.
   function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] p,
                                                 input logic [SLOT_W-1:0] o);
      logic [SLOT_W:0] sum;
      sum = {1'b0, p} + {1'b0, o};
      if (sum >= (SLOT_W+1)'(SLOTS)) begin
         sum = sum - (SLOT_W+1)'(SLOTS);
      end
      add_mod = sum[SLOT_W-1:0];
   endfunction

   assign out_free = !out_valid_ff || rsp_ready;
   assign cur_idx  = cur_ff[IDX_W-1:0];

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         lvl_ff        <= '0;
         pos_ff        <= '{default: '0};
         free_head_ff  <= '0;
         nid_ff        <= ID_W'(1);
         live_ff       <= '0;
         canc_ff       <= '0;
         pend_ff       <= 1'b0;
         fire_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lvl_ff        <= lvl_in;
         pos_ff        <= pos_in;
         free_head_ff  <= free_head_in;
         nid_ff        <= nid_in;
         live_ff       <= live_in;
         canc_ff       <= canc_in;
         pend_ff       <= pend_in;
         fire_valid_ff <= fire_valid_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and response payload.
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      nxt_ff         <= nxt_in;
      off_ff         <= off_in;
      cid_ff         <= cid_in;
      scan_ff        <= scan_in;
      pidx_ff        <= pidx_in;
      fire_id_ff     <= fire_id_in;
      emit_status_ff <= emit_status_in;
      slot_sel_ff    <= slot_sel_in;
      if (out_load) begin
         out_status_ff <= load_status;
         out_id_ff     <= load_id;
         out_last_ff   <= load_last;
      end
   end

   // Sequencer: next state, memory accesses and response loads.
   always_comb begin
      state_in       = state_ff;
      lvl_in         = lvl_ff;
      pos_in         = pos_ff;
      free_head_in   = free_head_ff;
      nid_in         = nid_ff;
      live_in        = live_ff;
      canc_in        = canc_ff;
      cur_in         = cur_ff;
      nxt_in         = nxt_ff;
      off_in         = off_ff;
      cid_in         = cid_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      pidx_in        = pidx_ff;
      fire_valid_in  = fire_valid_ff;
      fire_id_in     = fire_id_ff;
      emit_status_in = emit_status_ff;
      slot_sel_in    = slot_sel_ff;
      pos_next       = '0;

      req_ready      = 1'b0;
      out_load       = 1'b0;
      load_status    = STAT_TICK_EMPTY;
      load_id        = '0;
      load_last      = 1'b1;

      ent_rd_en      = 1'b0;
      ent_rd_addr    = '0;
      ent_wr_id_en   = 1'b0;
      ent_wr_link_en = 1'b0;
      ent_wr_addr    = cur_idx;
      ent_wr_id      = nid_ff;
      ent_wr_link    = free_head_ff;
      slot_rd_en     = 1'b0;
      slot_rd_addr   = '0;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = '0;
      slot_wr_head   = NIL;
      div_start      = 1'b0;
      div_dividend   = ID_W'(off_ff);

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (kind_type'(req_kind))
                  KIND_SCHEDULE: begin
                     if (free_head_ff == NIL) begin
                        emit_status_in = STAT_POOL_FULL;
                        state_in       = S_EMIT;
                     end else begin
                        off_in   = (req_delay_ticks > max_delay_ticks) ? max_delay_ticks
                                                                       : req_delay_ticks;
                        lvl_in   = '0;
                        state_in = S_SCH_LVL;
                     end
                  end
                  KIND_CANCEL: begin
                     cid_in   = req_cancel_id;
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_CAN_SCAN;
                  end
                  KIND_TICK: begin
                     // Advance level 0 and take its new slot, leaving it empty.
                     pos_next      = pos_inc(pos_ff[0]);
                     pos_in[0]     = pos_next;
                     slot_rd_en    = 1'b1;
                     slot_rd_addr  = slot_addr('0, pos_next);
                     slot_wr_en    = 1'b1;
                     slot_wr_addr  = slot_addr('0, pos_next);
                     slot_wr_head  = NIL;
                     fire_valid_in = 1'b0;
                     state_in      = S_TICK_HEAD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               load_status = emit_status_ff;
               load_id     = '0;
               load_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end

         // Walk the pool in index order, one read per cycle, compare each id in the cycle after its read.
         S_CAN_SCAN: begin
            if (scan_ff < PTR_W'(POOL_ENTRIES)) begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = scan_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pidx_in     = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + PTR_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (live_ff[pidx_ff] && !canc_ff[pidx_ff] && ent_rd_id == cid_ff) begin
                  canc_in[pidx_ff] = 1'b1;
                  emit_status_in   = STAT_CANCEL_DONE;
                  state_in         = S_EMIT;
               end else if (pidx_ff == IDX_W'(POOL_ENTRIES - 1)) begin
                  emit_status_in = STAT_CANCEL_DONE;
                  state_in       = S_EMIT;
               end
            end
         end

         // Pick the level: divide the offset by SLOTS until it fits, else offset SLOTS-1 at the top.
         S_SCH_LVL: begin
            if (off_ff < DELAY_W'(SLOTS)) begin
               slot_sel_in = add_mod(pos_ff[lvl_ff], off_ff[SLOT_W-1:0]);
               state_in    = S_SCH_RD;
            end else if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               slot_sel_in = add_mod(pos_ff[lvl_ff], SLOT_W'(SLOTS - 1));
               state_in    = S_SCH_RD;
            end else begin
               div_start    = 1'b1;
               div_dividend = ID_W'(off_ff);
               state_in     = S_SCH_DIV;
            end
         end

         S_SCH_DIV: begin
            if (!div_busy) begin
               off_in   = div_quotient[DELAY_W-1:0];
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_SCH_LVL;
            end
         end

         S_SCH_RD: begin
            ent_rd_en    = 1'b1;
            ent_rd_addr  = free_head_ff[IDX_W-1:0];
            slot_rd_en   = 1'b1;
            slot_rd_addr = slot_addr(lvl_ff, slot_sel_ff);
            state_in     = S_SCH_WR;
         end

         // Pop the free entry and push it on the head of the target slot.
         S_SCH_WR: begin
            if (out_free) begin
               free_head_in   = ent_rd_link;
               ent_wr_id_en   = 1'b1;
               ent_wr_link_en = 1'b1;
               ent_wr_addr    = free_head_ff[IDX_W-1:0];
               ent_wr_id      = nid_ff;
               ent_wr_link    = slot_rd_head;
               slot_wr_en     = 1'b1;
               slot_wr_addr   = slot_addr(lvl_ff, slot_sel_ff);
               slot_wr_head   = free_head_ff;
               live_in[free_head_ff[IDX_W-1:0]] = 1'b1;
               canc_in[free_head_ff[IDX_W-1:0]] = 1'b0;
               out_load       = 1'b1;
               load_status    = STAT_SCHEDULED;
               load_id        = nid_ff;
               load_last      = 1'b1;
               nid_in         = nid_ff + ID_W'(1);
               state_in       = S_IDLE;
            end
         end

         S_TICK_HEAD: begin
            cur_in = slot_rd_head;
            if (slot_rd_head == NIL) begin
               state_in = S_TICK_FIN;
            end else begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = slot_rd_head[IDX_W-1:0];
               state_in    = S_WALK;
            end
         end

         // One entry per cycle while the output is not stalled: fire it unless cancelled, then
         // return it to the pool. The last fired id is held back so that it can carry the last flag.
         S_WALK: begin
            if (!(!canc_ff[cur_idx] && fire_valid_ff && !out_free)) begin
               if (!canc_ff[cur_idx]) begin
                  if (fire_valid_ff) begin
                     out_load    = 1'b1;
                     load_status = STAT_FIRED;
                     load_id     = fire_id_ff;
                     load_last   = 1'b0;
                  end
                  fire_valid_in = 1'b1;
                  fire_id_in    = ent_rd_id;
               end
               live_in[cur_idx] = 1'b0;
               canc_in[cur_idx] = 1'b0;
               ent_wr_link_en   = 1'b1;
               ent_wr_addr      = cur_idx;
               ent_wr_link      = free_head_ff;
               free_head_in     = cur_ff;
               cur_in           = ent_rd_link;
               if (ent_rd_link == NIL) begin
                  state_in = S_TICK_FIN;
               end else begin
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = ent_rd_link[IDX_W-1:0];
               end
            end
         end

         S_TICK_FIN: begin
            if (out_free) begin
               out_load    = 1'b1;
               load_status = fire_valid_ff ? STAT_FIRED : STAT_TICK_EMPTY;
               load_id     = fire_valid_ff ? fire_id_ff : '0;
               load_last   = 1'b1;
               if (LEVELS > 1 && pos_ff[0] == '0) begin
                  lvl_in   = LVL_W'(1);
                  state_in = S_CAS_ADV;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // Advance an upper level and take its new slot.
         S_CAS_ADV: begin
            pos_next       = pos_inc(pos_ff[lvl_ff]);
            pos_in[lvl_ff] = pos_next;
            slot_rd_en     = 1'b1;
            slot_rd_addr   = slot_addr(lvl_ff, pos_next);
            slot_wr_en     = 1'b1;
            slot_wr_addr   = slot_addr(lvl_ff, pos_next);
            slot_wr_head   = NIL;
            state_in       = S_CAS_HEAD;
         end

         S_CAS_HEAD: begin
            cur_in = slot_rd_head;
            if (slot_rd_head == NIL) begin
               state_in = S_CAS_NEXT;
            end else begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = slot_rd_head[IDX_W-1:0];
               state_in    = S_CAS_USE;
            end
         end

         // Cancelled entries go back to the pool; live ones move one level down.
         S_CAS_USE: begin
            if (canc_ff[cur_idx]) begin
               live_in[cur_idx] = 1'b0;
               canc_in[cur_idx] = 1'b0;
               ent_wr_link_en   = 1'b1;
               ent_wr_addr      = cur_idx;
               ent_wr_link      = free_head_ff;
               free_head_in     = cur_ff;
               cur_in           = ent_rd_link;
               if (ent_rd_link == NIL) begin
                  state_in = S_CAS_NEXT;
               end else begin
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = ent_rd_link[IDX_W-1:0];
               end
            end else begin
               nxt_in       = ent_rd_link;
               div_start    = 1'b1;
               div_dividend = ent_rd_id;
               state_in     = S_CAS_DIV;
            end
         end

         S_CAS_DIV: begin
            if (!div_busy) begin
               slot_sel_in = div_remainder;
               state_in    = S_CAS_RD;
            end
         end

         S_CAS_RD: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = slot_addr(lvl_ff - LVL_W'(1), slot_sel_ff);
            state_in     = S_CAS_WR;
         end

         S_CAS_WR: begin
            ent_wr_link_en = 1'b1;
            ent_wr_addr    = cur_idx;
            ent_wr_link    = slot_rd_head;
            slot_wr_en     = 1'b1;
            slot_wr_addr   = slot_addr(lvl_ff - LVL_W'(1), slot_sel_ff);
            slot_wr_head   = cur_ff;
            cur_in         = nxt_ff;
            if (nxt_ff == NIL) begin
               state_in = S_CAS_NEXT;
            end else begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = nxt_ff[IDX_W-1:0];
               state_in    = S_CAS_USE;
            end
         end

         // Carry into the next level only when this one wrapped.
         S_CAS_NEXT: begin
            if (pos_ff[lvl_ff] != '0 || lvl_ff == LVL_W'(LEVELS - 1)) begin
               state_in = S_IDLE;
            end else begin
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_CAS_ADV;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_timer_id = out_id_ff;
   assign rsp_last     = out_last_ff;
endmodule

// ===== tb/tb.sv =====
module tb;
   import htw_pkg::*;

   localparam int NSLOT   = 64;
   localparam int NLEVEL  = 4;
   localparam int NPOOL   = 64;
   localparam int NIL     = NPOOL;
   // Cascades after a wrap can keep the wheel busy after the last response.
   localparam int SETTLE  = 3000;
   localparam int WD_LIMIT = 20000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DELAY_W-1:0] delay_ticks;
      logic [ID_W-1:0]    cancel_id;
   } request_t;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] timer_id;
      logic            last;
   } response_t;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   htw_req_if req_ch ();
   htw_rsp_if rsp_ch ();

   hierarchical_timer_wheel u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the wheel state.
   logic [DELAY_W-1:0] max_delay;
   logic [ID_W-1:0]    timer_ids [NPOOL];
   bit                 cancelled [NPOOL];
   bit                 live [NPOOL];
   int                 link [NPOOL];
   int                 slot_head [NLEVEL*NSLOT];
   int                 position [NLEVEL];
   int                 free_head;
   logic [ID_W-1:0]    next_id;

   request_t  pending_requests [$];
   response_t expected_responses [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int idle_cycles = 0;
   int n_scheduled = 0, n_fired = 0, n_full = 0, n_cancel = 0, n_empty_tick = 0;
   int n_checked = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void wheel_reset();
      max_delay = MAX_DELAY_RESET;
      for (int i = 0; i < NPOOL; i++) begin
         timer_ids[i] = '0;
         cancelled[i] = 0;
         live[i] = 0;
         link[i] = i + 1;
      end
      for (int i = 0; i < NLEVEL*NSLOT; i++) slot_head[i] = NIL;
      for (int i = 0; i < NLEVEL; i++) position[i] = 0;
      free_head = 0;
      next_id = 1;
   endfunction

   function automatic void wheel_link(int lvl, int slot, int e);
      link[e] = slot_head[lvl*NSLOT + slot];
      slot_head[lvl*NSLOT + slot] = e;
   endfunction

   function automatic void wheel_free(int e);
      live[e] = 0;
      cancelled[e] = 0;
      link[e] = free_head;
      free_head = e;
   endfunction

   // Computes the responses that one accepted request causes.
   function automatic void wheel_step(request_t rq);
      int lvl, offset, e, cur, nxt, s;
      logic [DELAY_W-1:0] d;
      logic [ID_W-1:0] fired [$];
      case (kind_type'(rq.kind))
         KIND_SCHEDULE: begin
            if (free_head >= NPOOL) begin
               expected_responses.push_back('{STAT_POOL_FULL, '0, 1'b1});
            end else begin
               d = (rq.delay_ticks > max_delay) ? max_delay : rq.delay_ticks;
               lvl = NLEVEL - 1;
               offset = NSLOT - 1;
               for (int i = 0; i < NLEVEL; i++) begin
                  if (d < NSLOT) begin
                     lvl = i;
                     offset = d;
                     break;
                  end
                  d = d / NSLOT;
               end
               e = free_head;
               free_head = link[e];
               timer_ids[e] = next_id;
               live[e] = 1;
               cancelled[e] = 0;
               wheel_link(lvl, (position[lvl] + offset) % NSLOT, e);
               expected_responses.push_back('{STAT_SCHEDULED, next_id, 1'b1});
               next_id = next_id + 1;
            end
         end
         KIND_CANCEL: begin
            for (int i = 0; i < NPOOL; i++) begin
               if (live[i] && !cancelled[i] && timer_ids[i] == rq.cancel_id) begin
                  cancelled[i] = 1;
                  break;
               end
            end
            expected_responses.push_back('{STAT_CANCEL_DONE, '0, 1'b1});
         end
         KIND_TICK: begin
            position[0] = (position[0] + 1) % NSLOT;
            cur = slot_head[position[0]];
            slot_head[position[0]] = NIL;
            for (int g = 0; cur < NPOOL && g < NPOOL; g++) begin
               nxt = link[cur];
               if (!cancelled[cur]) fired.push_back(timer_ids[cur]);
               wheel_free(cur);
               cur = nxt;
            end
            // Level 0 wrapped: advance the upper levels and pull entries down.
            if (position[0] == 0) begin
               for (int l = 1; l < NLEVEL; l++) begin
                  position[l] = (position[l] + 1) % NSLOT;
                  s = l*NSLOT + position[l];
                  cur = slot_head[s];
                  slot_head[s] = NIL;
                  for (int g = 0; cur < NPOOL && g < NPOOL; g++) begin
                     nxt = link[cur];
                     if (cancelled[cur]) wheel_free(cur);
                     else wheel_link(l - 1, timer_ids[cur] % NSLOT, cur);
                     cur = nxt;
                  end
                  if (position[l] != 0) break;
               end
            end
            if (fired.size() == 0) begin
               expected_responses.push_back('{STAT_TICK_EMPTY, '0, 1'b1});
            end else begin
               foreach (fired[i]) begin
                  expected_responses.push_back(
                     '{STAT_FIRED, fired[i], (i == fired.size() - 1)});
               end
            end
         end
         default: begin
            // The unused kind is dropped without any response.
         end
      endcase
   endfunction

   // Request driver: offers the queue head, holding it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            wheel_step(pending_requests.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid       <= 1'b1;
               req_ch.kind        <= pending_requests[0].kind;
               req_ch.delay_ticks <= pending_requests[0].delay_ticks;
               req_ch.cancel_id   <= pending_requests[0].cancel_id;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = 600;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      response_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response: status %0d id %0h last %0b",
                   rsp_ch.status, rsp_ch.timer_id, rsp_ch.last);
            errors++;
         end else begin
            want = expected_responses.pop_front();
            n_checked++;
            case (want.status)
               STAT_SCHEDULED:   n_scheduled++;
               STAT_POOL_FULL:   n_full++;
               STAT_FIRED:       n_fired++;
               STAT_TICK_EMPTY:  n_empty_tick++;
               default:          n_cancel++;
            endcase
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.timer_id !== want.timer_id) begin
               $error("timer_id: expected %0h, got %0h", want.timer_id, rsp_ch.timer_id);
               errors++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(logic [DELAY_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(REG_MAX_DELAY) << 2;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      max_delay = value;
   endtask

   task automatic add_request(kind_type k, int unsigned d, logic [ID_W-1:0] cid);
      pending_requests.push_back('{k, DELAY_W'(d), cid});
   endtask

   function automatic logic [DELAY_W-1:0] pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 50) return DELAY_W'($urandom_range(63));
      if (r < 75) return DELAY_W'($urandom_range(4095, 64));
      if (r < 85) return DELAY_W'($urandom_range(300000, 4096));
      return DELAY_W'($urandom);
   endfunction

   // Fills one phase with random requests; sched_pct shifts the mix.
   task automatic add_random(int count, int sched_pct);
      int r;
      logic [ID_W-1:0] cid;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < sched_pct) begin
            add_request(KIND_SCHEDULE, pick_delay(), $urandom);
         end else if (r < sched_pct + 12) begin
            if ($urandom_range(3) == 0) cid = $urandom;
            else cid = $urandom_range(next_id + 10);
            add_request(KIND_CANCEL, $urandom, cid);
         end else if (r < 99) begin
            add_request(KIND_TICK, $urandom, $urandom);
         end else begin
            pending_requests.push_back('{KIND_UNUSED, DELAY_W'($urandom), ID_W'($urandom)});
         end
      end
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_responses.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int idle_mode [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{23, 23}};
      logic [DELAY_W-1:0] limits [6] = '{DELAY_W'(16777215), DELAY_W'(0),
                                         DELAY_W'(63), DELAY_W'(4095),
                                         DELAY_W'(540000), DELAY_W'(200)};
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.delay_ticks = '0;
      req_ch.cancel_id = '0;
      rsp_ch.ready = 1'b0;
      wheel_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every kind, zero offset, clamping, cancels.
      csr_write(DELAY_W'(540000));
      add_request(KIND_SCHEDULE, 0, '0);
      add_request(KIND_SCHEDULE, 1, '0);
      add_request(KIND_SCHEDULE, 63, '0);
      add_request(KIND_SCHEDULE, 64, '0);
      add_request(KIND_SCHEDULE, 4095, '0);
      add_request(KIND_SCHEDULE, 4096, '0);
      add_request(KIND_SCHEDULE, 262143, '0);
      add_request(KIND_SCHEDULE, 262144, '0);
      add_request(KIND_SCHEDULE, 16777215, '1);
      add_request(KIND_CANCEL, 0, 32'd4);
      add_request(KIND_CANCEL, 0, 32'd4);
      add_request(KIND_CANCEL, 0, 32'hFFFF_FFFF);
      add_request(KIND_CANCEL, 16777215, 32'd0);
      pending_requests.push_back('{KIND_UNUSED, '1, '1});
      add_request(KIND_TICK, 0, '0);
      add_request(KIND_TICK, 0, '0);
      add_request(KIND_CANCEL, 0, 32'd3);
      for (int i = 0; i < 6; i++) add_request(KIND_TICK, 0, '0);
      drain();

      // Random phases over several limits and idle patterns.
      for (int p = 0; p < 6; p++) begin
         csr_write(limits[p]);
         send_idle_pct = idle_mode[p % 4][0];
         stall_pct = idle_mode[p % 4][1];
         if (p == 0) begin
            // Mostly schedules so the pool runs out.
            add_random(70, 80);
         end else begin
            add_random(50, 35);
         end
         if (p == 2) hold_asked++;
         drain();
      end
      // Long tick run so cascades from the upper levels come due.
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 40; i++) add_request(KIND_TICK, 0, '0);
      drain();

      $display("Checked %0d responses: %0d scheduled, %0d fired, %0d pool full,",
               n_checked, n_scheduled, n_fired, n_full);
      $display("  %0d cancels, %0d empty ticks, over six delay limits.",
               n_cancel, n_empty_tick);
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
